### sv/srpc_pkg.sv
// srpc_pkg: shared types and constants for the stepper ramp position controller
// holds the request structs, configuration struct, event and mode codes
// no dependencies
`default_nettype none

package srpc_pkg;

  // field widths
  localparam int COMPARE_W = 16;
  localparam int COUNT_W   = 16;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // reset values of the configuration registers
  localparam logic [COMPARE_W-1:0] ACCEL_STEP_RST   = COMPARE_W'(1);
  localparam logic [COUNT_W-1:0]   TARGET_COUNT_RST = COUNT_W'(1000);
  localparam logic                 DIRECTION_RST    = 1'b1;

  // motor modes
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_ACCEL   = 2'd1,
    MODE_RUN     = 2'd2,
    MODE_BRAKE   = 2'd3
  } mode_t;

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 3'd0,
    KIND_STOP   = 3'd1,
    KIND_BRAKE  = 3'd2,
    KIND_CALIB  = 3'd3,
    KIND_TICK   = 3'd4,
    KIND_COUNT  = 3'd5,
    KIND_INDEX  = 3'd6,
    KIND_UNUSED = 3'd7
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_SPEED   = 3'd0,
    REG_MIN_SPEED   = 3'd1,
    REG_CALIB_SPEED = 3'd2,
    REG_ACCEL_STEP  = 3'd3,
    REG_TARGET_CNT  = 3'd4,
    REG_BRAKE_NEAR  = 3'd5,
    REG_BRAKE_FAR   = 3'd6,
    REG_DIRECTION   = 3'd7
  } cfg_idx_t;

  // input request
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] steps;
  } in_item_t;

  // result request
  typedef struct packed {
    logic [COMPARE_W-1:0] pwm_compare;
    logic [1:0]           motor_state;
    logic                 far_half;
    logic                 calibrated;
    logic                 direction_pin;
    logic                 counter_clear;
    logic [COUNT_W-1:0]   captured_steps;
  } out_item_t;

  // configuration handed from the register file to the core
  typedef struct packed {
    logic [COMPARE_W-1:0] run_speed;
    logic [COMPARE_W-1:0] min_speed;
    logic [COMPARE_W-1:0] calib_speed;
    logic [COMPARE_W-1:0] accel_step;
    logic [COUNT_W-1:0]   target_count;
    logic [COUNT_W-1:0]   brake_point_near;
    logic [COUNT_W-1:0]   brake_point_far;
    logic                 direction;
  } cfg_t;

endpackage

`default_nettype wire

### sv/srpc_cfg_regs.sv
// srpc_cfg_regs: configuration register file of the ramp controller
// depends on srpc_pkg for the register indexes and the cfg_t struct
`default_nettype none

module srpc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [srpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [srpc_pkg::CFG_DAT_W-1:0] wr_data,
  output srpc_pkg::cfg_t                     cfg
);

  srpc_pkg::cfg_t cfg_r;
  srpc_pkg::cfg_t cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (srpc_pkg::cfg_idx_t'(wr_index))
        srpc_pkg::REG_RUN_SPEED:   cfg_nxt.run_speed        = wr_data;
        srpc_pkg::REG_MIN_SPEED:   cfg_nxt.min_speed        = wr_data;
        srpc_pkg::REG_CALIB_SPEED: cfg_nxt.calib_speed      = wr_data;
        srpc_pkg::REG_ACCEL_STEP:  cfg_nxt.accel_step       = wr_data;
        srpc_pkg::REG_TARGET_CNT:  cfg_nxt.target_count     = wr_data;
        srpc_pkg::REG_BRAKE_NEAR:  cfg_nxt.brake_point_near = wr_data;
        srpc_pkg::REG_BRAKE_FAR:   cfg_nxt.brake_point_far  = wr_data;
        srpc_pkg::REG_DIRECTION:   cfg_nxt.direction        = wr_data[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_speed        <= '0;
      cfg_r.min_speed        <= '0;
      cfg_r.calib_speed      <= '0;
      cfg_r.accel_step       <= srpc_pkg::ACCEL_STEP_RST;
      cfg_r.target_count     <= srpc_pkg::TARGET_COUNT_RST;
      cfg_r.brake_point_near <= '0;
      cfg_r.brake_point_far  <= '0;
      cfg_r.direction        <= srpc_pkg::DIRECTION_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### sv/srpc_core.sv
// srpc_core: motor mode state machine, ramp arithmetic and encoder checks
// depends on srpc_pkg; state updates on each accepted request
`default_nettype none

module srpc_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire srpc_pkg::in_item_t  item,
  input  wire srpc_pkg::cfg_t      cfg,
  output srpc_pkg::out_item_t      result
);

  srpc_pkg::mode_t                 mode_r, mode_nxt;
  logic [srpc_pkg::COMPARE_W-1:0]  cmp_r, cmp_nxt;
  logic                            half_r, half_nxt;
  logic                            zero_r, zero_nxt;
  logic                            ovr_r, ovr_nxt;
  logic [srpc_pkg::COUNT_W-1:0]    latch_r, latch_nxt;
  logic                            dir_r, dir_nxt;
  logic                            clear;

  logic [srpc_pkg::COMPARE_W-1:0]  target;
  logic [srpc_pkg::COMPARE_W:0]    sum;
  logic [srpc_pkg::COMPARE_W-1:0]  cmp_up;
  logic [srpc_pkg::COMPARE_W-1:0]  cmp_down;
  logic                            hit_near, hit_target, hit_far;

  // ramp arithmetic
  assign target   = ovr_r ? cfg.calib_speed : cfg.run_speed;
  assign sum      = {1'b0, cmp_r} + {1'b0, cfg.accel_step};
  assign cmp_up   = sum[srpc_pkg::COMPARE_W] ? '1 : sum[srpc_pkg::COMPARE_W-1:0];
  assign cmp_down = (cmp_r > cfg.accel_step) ? (cmp_r - cfg.accel_step) : '0;

  // encoder threshold compares
  assign hit_near   = (item.steps >= cfg.brake_point_near);
  assign hit_target = (item.steps >= cfg.target_count);
  assign hit_far    = (item.steps >= cfg.brake_point_far);

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    cmp_nxt   = cmp_r;
    half_nxt  = half_r;
    zero_nxt  = zero_r;
    ovr_nxt   = ovr_r;
    latch_nxt = latch_r;
    dir_nxt   = dir_r;
    clear     = 1'b0;
    unique case (srpc_pkg::kind_t'(item.kind))
      srpc_pkg::KIND_START: begin
        if (mode_r == srpc_pkg::MODE_STOPPED) begin
          dir_nxt  = cfg.direction;
          mode_nxt = srpc_pkg::MODE_ACCEL;
        end
      end
      srpc_pkg::KIND_STOP: begin
        if (mode_r == srpc_pkg::MODE_RUN || mode_r == srpc_pkg::MODE_BRAKE) begin
          cmp_nxt  = '0;
          mode_nxt = srpc_pkg::MODE_STOPPED;
        end
      end
      srpc_pkg::KIND_BRAKE: begin
        if (mode_r == srpc_pkg::MODE_RUN) begin
          mode_nxt = srpc_pkg::MODE_BRAKE;
        end
      end
      srpc_pkg::KIND_CALIB: begin
        zero_nxt = 1'b0;
        ovr_nxt  = 1'b1;
        if (mode_r == srpc_pkg::MODE_STOPPED) begin
          dir_nxt  = cfg.direction;
          mode_nxt = srpc_pkg::MODE_ACCEL;
        end
      end
      srpc_pkg::KIND_TICK: begin
        if (mode_r == srpc_pkg::MODE_ACCEL) begin
          if (cmp_r < target) begin
            cmp_nxt = cmp_up;
          end else begin
            cmp_nxt  = target;
            mode_nxt = srpc_pkg::MODE_RUN;
          end
        end else if (mode_r == srpc_pkg::MODE_BRAKE) begin
          cmp_nxt = (cmp_r > cfg.min_speed) ? cmp_down : cfg.min_speed;
        end
      end
      srpc_pkg::KIND_COUNT: begin
        // near brake point, then half-turn stop, then far brake point
        if (hit_near && !half_r && zero_r && mode_r == srpc_pkg::MODE_RUN) begin
          mode_nxt = srpc_pkg::MODE_BRAKE;
        end
        if (hit_target && !half_r && zero_r) begin
          latch_nxt = item.steps;
          half_nxt  = 1'b1;
          if (mode_nxt == srpc_pkg::MODE_RUN || mode_nxt == srpc_pkg::MODE_BRAKE) begin
            cmp_nxt  = '0;
            mode_nxt = srpc_pkg::MODE_STOPPED;
          end
        end
        if (hit_far && half_nxt && zero_r && mode_nxt == srpc_pkg::MODE_RUN) begin
          mode_nxt = srpc_pkg::MODE_BRAKE;
        end
      end
      srpc_pkg::KIND_INDEX: begin
        if (!zero_r) begin
          zero_nxt = 1'b1;
          ovr_nxt  = 1'b0;
        end
        clear     = 1'b1;
        latch_nxt = '0;
        half_nxt  = 1'b0;
        if (mode_r == srpc_pkg::MODE_RUN || mode_r == srpc_pkg::MODE_BRAKE) begin
          cmp_nxt  = '0;
          mode_nxt = srpc_pkg::MODE_STOPPED;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  // result fields from the updated state
  always_comb begin
    result.pwm_compare    = cmp_nxt;
    result.motor_state    = mode_nxt;
    result.far_half       = half_nxt;
    result.calibrated     = zero_nxt;
    result.direction_pin  = dir_nxt;
    result.counter_clear  = clear;
    result.captured_steps = latch_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= srpc_pkg::MODE_STOPPED;
      cmp_r   <= '0;
      half_r  <= 1'b0;
      zero_r  <= 1'b0;
      ovr_r   <= 1'b0;
      latch_r <= '0;
      dir_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      cmp_r   <= cmp_nxt;
      half_r  <= half_nxt;
      zero_r  <= zero_nxt;
      ovr_r   <= ovr_nxt;
      latch_r <= latch_nxt;
      dir_r   <= dir_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/stepper_ramp_position_controller.sv
// stepper_ramp_position_controller: top level of the motor speed-ramp controller
// depends on srpc_pkg, srpc_cfg_regs and srpc_core
//
//   channel   signals                           handshake
//   in_       in_valid, in_stall, in_data       valid high, stall low
//   out_      out_valid, out_stall, out_data    valid high, stall low
//   cfg_      cfg_valid, cfg_ready, cfg_index,  valid and ready high
//             cfg_data
//
// one request per cycle while in_stall is low; its result shows in the output register in the
// cycle after acceptance, the core's compare and 17-bit add being combinational
// reset (synchronous, rst_n low) empties the output register and returns to stopped
// in_stall is high only while a result sits in the output register and out_stall
// holds it; cfg_ready is always high
`default_nettype none

module stepper_ramp_position_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire srpc_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output srpc_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srpc_pkg::CFG_DAT_W-1:0] cfg_data
);

  srpc_pkg::cfg_t      cfg;
  srpc_pkg::out_item_t result;
  srpc_pkg::out_item_t out_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                in_acc;

  // handshake
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  srpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  srpc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // output register
  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
